// File: rtl/tpa_pkg.sv
// Package for the triangle primitive assembler.
// Holds the index width, the topology codes and the structs shared by the modules.
// No dependencies.
package tpa_pkg;

  localparam int INDEX_BITS = 32;
  localparam int PORT_INDEX_BITS = 32;

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef enum logic [1:0] {
    TOPO_LIST  = 2'd0,
    TOPO_STRIP = 2'd1,
    TOPO_FAN   = 2'd2,
    TOPO_NONE  = 2'd3
  } topology_t;

  typedef struct packed {
    index_t vertex_index;
    logic   starts_primitive;
  } step_t;

  typedef struct packed {
    logic   valid;
    index_t corner_a;
    index_t corner_b;
    index_t corner_c;
  } tri_t;

endpackage

// File: rtl/tpa_assembler.sv
// Assembly state and triangle formation for one registered index per cycle while advance is high.
// Depends on tpa_pkg.
module tpa_assembler (
  input  logic              clk,
  input  logic              rst,
  input  tpa_pkg::topology_t topology,
  input  logic              advance,
  input  tpa_pkg::step_t    step,
  output tpa_pkg::tri_t     result
);
  import tpa_pkg::*;

  index_t      older_index;
  index_t      newer_index;
  index_t      fan_anchor;
  logic [1:0]  seen_count;
  logic        odd_triangle;

  index_t      older_index_next;
  index_t      newer_index_next;
  index_t      fan_anchor_next;
  logic [1:0]  seen_count_next;
  logic        odd_triangle_next;

  logic [1:0]  count_in;
  logic        odd_in;
  index_t      v;
  index_t      ta;
  index_t      tb;
  logic        emit;

  always_comb begin
    v        = step.vertex_index;
    count_in = step.starts_primitive ? 2'd0 : seen_count;
    odd_in   = step.starts_primitive ? 1'b0 : odd_triangle;

    older_index_next  = older_index;
    newer_index_next  = newer_index;
    fan_anchor_next   = fan_anchor;
    seen_count_next   = count_in;
    odd_triangle_next = odd_in;
    ta   = older_index;
    tb   = newer_index;
    emit = 1'b0;

    if (topology != TOPO_NONE) begin
      case (count_in)
        2'd0: begin
          older_index_next = v;
          fan_anchor_next  = v;
          seen_count_next  = 2'd1;
        end
        2'd1: begin
          newer_index_next = v;
          seen_count_next  = 2'd2;
        end
        default: begin
          emit = 1'b1;
          case (topology)
            TOPO_LIST: begin
              seen_count_next = 2'd0;
            end
            TOPO_STRIP: begin
              if (odd_in) begin
                ta = newer_index;
                tb = older_index;
              end
              odd_triangle_next = ~odd_in;
              older_index_next  = newer_index;
              newer_index_next  = v;
            end
            default: begin
              ta               = fan_anchor;
              older_index_next = newer_index;
              newer_index_next = v;
            end
          endcase
        end
      endcase
    end

    // Degenerate triangles are dropped but still advance the strip order.
    result.valid    = emit && (ta != tb) && (ta != v) && (tb != v);
    result.corner_a = ta;
    result.corner_b = tb;
    result.corner_c = v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_index  <= '0;
      newer_index  <= '0;
      fan_anchor   <= '0;
      seen_count   <= 2'd0;
      odd_triangle <= 1'b0;
    end else if (advance) begin
      older_index  <= older_index_next;
      newer_index  <= newer_index_next;
      fan_anchor   <= fan_anchor_next;
      seen_count   <= seen_count_next;
      odd_triangle <= odd_triangle_next;
    end
  end

endmodule

// File: rtl/triangle_primitive_assembler.sv
// Top level of the triangle primitive assembler: stream ports, input and result registers.
// Depends on tpa_pkg and tpa_assembler.
//
// The block takes one vertex index per cycle while its result is not stalled and returns
// at most one triangle per index: the index is held in an input register, then the assembly
// logic fills the result register. A new index request is accepted in every cycle while the
// result register is empty or its triangle is being taken; a stalled result holds one index
// in the input register and then stops the input side. The topology register may be written
// in any cycle but should change only while the block is idle.
module triangle_primitive_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,   // topology
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // vertex_index
  input  logic        s_tuser,    // starts_primitive
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata     // corner_a, corner_b, corner_c
);
  import tpa_pkg::*;

  topology_t topology;
  logic      in_valid;
  step_t     in_step;
  logic      advance;
  tri_t      result;
  logic [PORT_INDEX_BITS-1:0] out_a;
  logic [PORT_INDEX_BITS-1:0] out_b;
  logic [PORT_INDEX_BITS-1:0] out_c;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tdata   = {out_c, out_b, out_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      topology <= TOPO_LIST;
    end else if (cfg_valid && cfg_ready) begin
      topology <= topology_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_step.vertex_index     <= s_tdata[INDEX_BITS-1:0];
      in_step.starts_primitive <= s_tuser;
    end
  end

  tpa_assembler u_assembler (
    .clk      (clk),
    .rst      (rst),
    .topology (topology),
    .advance  (advance),
    .step     (in_step),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= advance && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid && (!m_tvalid || m_tready)) begin
      out_a <= PORT_INDEX_BITS'(result.corner_a);
      out_b <= PORT_INDEX_BITS'(result.corner_b);
      out_c <= PORT_INDEX_BITS'(result.corner_c);
    end
  end

endmodule

// File: rtl/tpa_checker.sv
// Port-level checks for the triangle primitive assembler and the bind that attaches them.
// Depends on triangle_primitive_assembler.
module tpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  // A stalled triangle must hold its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled triangle changed");

  // Whenever the result side can move, the input side must take a request.
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output free");

  // A delivered triangle never has two equal corners.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:0] != m_tdata[63:32]) && (m_tdata[31:0] != m_tdata[95:64])
                 && (m_tdata[63:32] != m_tdata[95:64]))
    else $error("degenerate triangle delivered");

  // Reset leaves no triangle pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("triangle pending after reset");

endmodule

bind triangle_primitive_assembler tpa_checker u_tpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
